// ===== hw/rtl/deef_pkg.sv =====
// Shared types, constants and helpers for the delimited element equality find unit.
package deef_pkg;

	localparam int FUNC_W   = 2;
	localparam int BYTE_W   = 8;
	localparam int IDX_W    = 6;
	localparam int LEN_W    = 7;
	localparam int OCC_W    = 24;
	localparam int OUT_W    = 24;

	localparam int PATTERN_MAX_DEF = 64;
	localparam int COUNT_WIDTH_DEF = 24;

	localparam logic [BYTE_W-1:0] MARK_FIELD    = 8'hFE;
	localparam logic [BYTE_W-1:0] MARK_VALUE    = 8'hFD;
	localparam logic [BYTE_W-1:0] MARK_SUBVALUE = 8'hFC;

	localparam logic [BYTE_W-1:0] LOWER_A     = 8'h61;
	localparam logic [BYTE_W-1:0] LOWER_Z     = 8'h7A;
	localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_START   = 2'd0,
		FUNC_PATTERN = 2'd1,
		FUNC_SOURCE  = 2'd2,
		FUNC_END     = 2'd3
	} func_t;

	function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c, input logic ci);
		if (ci && (c >= LOWER_A) && (c <= LOWER_Z)) begin
			return c - CASE_OFFSET;
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/deef_ifs.sv =====
// Command and result channel interfaces for the find unit.
interface deef_cmd_if;
	logic                            valid;
	logic                            ready;
	deef_pkg::func_t                 func;
	logic [deef_pkg::BYTE_W-1:0]     data_byte;
	logic [deef_pkg::IDX_W-1:0]      pattern_index;
	logic [deef_pkg::LEN_W-1:0]      pattern_length;
	logic [deef_pkg::OCC_W-1:0]      wanted_occurrence;

	modport source (
		output valid, func, data_byte, pattern_index, pattern_length, wanted_occurrence,
		input  ready
	);
	modport sink (
		input  valid, func, data_byte, pattern_index, pattern_length, wanted_occurrence,
		output ready
	);
endinterface

interface deef_res_if;
	logic                            valid;
	logic                            ready;
	logic                            found;
	logic [deef_pkg::OUT_W-1:0]      field_number;
	logic [deef_pkg::OUT_W-1:0]      value_number;
	logic [deef_pkg::OUT_W-1:0]      subvalue_number;

	modport source (
		output valid, found, field_number, value_number, subvalue_number,
		input  ready
	);
	modport sink (
		input  valid, found, field_number, value_number, subvalue_number,
		output ready
	);
endinterface

// ===== hw/rtl/deef_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module deef_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/delimited_element_equality_find_unit.sv =====
// Top level of the delimited element equality find unit.
// Takes one transaction per cycle on cmd: start (clears the search, sets pattern length and
// wanted occurrence), pattern byte, source byte or end of source. Each transaction passes an
// input register and is then processed; only end of source produces a result on res, which
// is loaded into the result register after the input register. cmd.ready falls only while an
// end-of-source transaction waits in the input register for a full, stalled result register.
// The pattern is held in a RAM with registered read, addressed ahead of time by the next
// match pointer, with a bypass for a pattern write to the entry being fetched. Reading a
// pattern entry never written since reset gives undefined compare data. case_insensitive is
// set through cfg_we/cfg_wdata and should change only while the unit is idle.
module delimited_element_equality_find_unit #(
	parameter int PATTERN_MAX = deef_pkg::PATTERN_MAX_DEF,
	parameter int COUNT_WIDTH = deef_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	deef_cmd_if.sink    cmd,
	deef_res_if.source  res
);

	localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int LW = $clog2(PATTERN_MAX + 1);
	localparam int BW = deef_pkg::BYTE_W;
	localparam int CW = COUNT_WIDTH;
	localparam int OW = deef_pkg::OCC_W;

	// configuration
	logic case_insensitive_q;

	// input stage
	logic                             valid_s1;
	deef_pkg::func_t                  func_s1;
	logic [BW-1:0]                    byte_s1;
	logic [deef_pkg::IDX_W-1:0]       idx_s1;
	logic [deef_pkg::LEN_W-1:0]       plen_s1;
	logic [OW-1:0]                    occ_s1;

	// search state
	logic [LW-1:0] plen_q, plen_d;
	logic [LW-1:0] mp_q, mp_d;
	logic          mm_q, mm_d;
	logic [OW-1:0] occ_q, occ_d;
	logic [CW-1:0] fcnt_q, fcnt_d;
	logic [CW-1:0] vcnt_q, vcnt_d;
	logic [CW-1:0] scnt_q, scnt_d;
	logic          hit_q, hit_d;
	logic          seen_q, seen_d;

	// pattern store access
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [BW-1:0] ram_rdata;
	logic          byp_q;
	logic [BW-1:0] byp_data_q;
	logic [BW-1:0] pat_byte;

	// control
	logic          advance;
	logic          fire_s1;
	logic          cmd_fire;
	logic          is_mark;
	logic          elem_match;
	logic          idx_ok;
	logic          found;

	// result register
	logic                        res_valid_q;
	logic                        res_found_q;
	logic [deef_pkg::OUT_W-1:0]  res_field_q;
	logic [deef_pkg::OUT_W-1:0]  res_value_q;
	logic [deef_pkg::OUT_W-1:0]  res_sub_q;

	assign advance   = (func_s1 != deef_pkg::FUNC_END) || !res_valid_q || res.ready;
	assign fire_s1   = valid_s1 && advance;
	assign cmd.ready = !valid_s1 || advance;
	assign cmd_fire  = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			case_insensitive_q <= 1'b0;
		end else if (cfg_we) begin
			case_insensitive_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			func_s1 <= cmd.func;
			byte_s1 <= cmd.data_byte;
			idx_s1  <= cmd.pattern_index;
			plen_s1 <= cmd.pattern_length;
			occ_s1  <= cmd.wanted_occurrence;
		end
	end

	assign pat_byte   = byp_q ? byp_data_q : ram_rdata;
	assign is_mark    = (byte_s1 == deef_pkg::MARK_FIELD) || (byte_s1 == deef_pkg::MARK_VALUE) ||
		(byte_s1 == deef_pkg::MARK_SUBVALUE);
	assign elem_match = !mm_q && (mp_q == plen_q);
	assign idx_ok     = 32'(idx_s1) < 32'(PATTERN_MAX);
	assign found      = hit_q || (seen_q && elem_match && (occ_q == OW'(1)));

	assign ram_we    = fire_s1 && (func_s1 == deef_pkg::FUNC_PATTERN) && idx_ok;
	assign ram_waddr = AW'(idx_s1);
	assign ram_raddr = mp_d[AW-1:0];

	always_comb begin
		plen_d = plen_q;
		mp_d   = mp_q;
		mm_d   = mm_q;
		occ_d  = occ_q;
		fcnt_d = fcnt_q;
		vcnt_d = vcnt_q;
		scnt_d = scnt_q;
		hit_d  = hit_q;
		seen_d = seen_q;
		if (fire_s1) begin
			case (func_s1)
				deef_pkg::FUNC_START: begin
					plen_d = (32'(plen_s1) > 32'(PATTERN_MAX)) ? LW'(PATTERN_MAX) : LW'(plen_s1);
					mp_d   = '0;
					mm_d   = 1'b0;
					occ_d  = occ_s1;
					fcnt_d = CW'(1);
					vcnt_d = CW'(1);
					scnt_d = CW'(1);
					hit_d  = 1'b0;
					seen_d = 1'b0;
				end
				deef_pkg::FUNC_SOURCE: begin
					seen_d = 1'b1;
					if (!hit_q) begin
						if (is_mark) begin
							if (elem_match && (occ_q == OW'(1))) begin
								occ_d = '0;
								hit_d = 1'b1;
							end else begin
								if (elem_match && (occ_q > OW'(1))) begin
									occ_d = occ_q - OW'(1);
								end
								mm_d = 1'b0;
								mp_d = '0;
								if (byte_s1 == deef_pkg::MARK_FIELD) begin
									fcnt_d = (&fcnt_q) ? fcnt_q : fcnt_q + CW'(1);
									vcnt_d = CW'(1);
									scnt_d = CW'(1);
								end else if (byte_s1 == deef_pkg::MARK_VALUE) begin
									vcnt_d = (&vcnt_q) ? vcnt_q : vcnt_q + CW'(1);
									scnt_d = CW'(1);
								end else begin
									scnt_d = (&scnt_q) ? scnt_q : scnt_q + CW'(1);
								end
							end
						end else if (!mm_q) begin
							if ((mp_q < plen_q) && (deef_pkg::fold(byte_s1, case_insensitive_q) ==
								deef_pkg::fold(pat_byte, case_insensitive_q))) begin
								mp_d = mp_q + LW'(1);
							end else begin
								mm_d = 1'b1;
								mp_d = '0;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= '0;
			mp_q   <= '0;
			mm_q   <= 1'b0;
			occ_q  <= '0;
			fcnt_q <= CW'(1);
			vcnt_q <= CW'(1);
			scnt_q <= CW'(1);
			hit_q  <= 1'b0;
			seen_q <= 1'b0;
			byp_q  <= 1'b0;
		end else begin
			plen_q <= plen_d;
			mp_q   <= mp_d;
			mm_q   <= mm_d;
			occ_q  <= occ_d;
			fcnt_q <= fcnt_d;
			vcnt_q <= vcnt_d;
			scnt_q <= scnt_d;
			hit_q  <= hit_d;
			seen_q <= seen_d;
			byp_q  <= ram_we && (ram_waddr == ram_raddr);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= byte_s1;
	end

	deef_ram #(
		.WIDTH (BW),
		.DEPTH (PATTERN_MAX)
	) u_pattern_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (byte_s1),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire_s1 && (func_s1 == deef_pkg::FUNC_END)) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && (func_s1 == deef_pkg::FUNC_END)) begin
			res_found_q <= found;
			res_field_q <= found ? deef_pkg::OUT_W'(fcnt_q) : '0;
			res_value_q <= found ? deef_pkg::OUT_W'(vcnt_q) : '0;
			res_sub_q   <= found ? deef_pkg::OUT_W'(scnt_q) : '0;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.found           = res_found_q;
	assign res.field_number    = res_field_q;
	assign res.value_number    = res_value_q;
	assign res.subvalue_number = res_sub_q;

`ifndef ASSERT_OFF
	a_mp_within_len: assert property (@(posedge clk) disable iff (!arst_n)
		mp_q <= plen_q)
		else $error("match pointer beyond pattern length");

	a_mismatch_ptr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		mm_q |-> (mp_q == '0))
		else $error("match pointer not cleared after mismatch");

	a_hit_occ_zero: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q |-> (occ_q == '0))
		else $error("hit with occurrences outstanding");

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && (func_s1 == deef_pkg::FUNC_END)) |=> res_valid_q)
		else $error("end of source did not load a result");

	a_hit_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(hit_q && !(fire_s1 && (func_s1 == deef_pkg::FUNC_START))) |=>
			(hit_q && $stable(fcnt_q) && $stable(vcnt_q) && $stable(scnt_q)))
		else $error("position moved after hit");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the delimited element equality find unit, with predicted answers.
module testbench;

	localparam int unsigned CYCLE_LIMIT  = 300000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned PHASE_ITEMS  = 150;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned HOLD_EVERY   = 300;

	typedef struct packed {
		deef_pkg::func_t                  func;
		logic [deef_pkg::BYTE_W-1:0]      data_byte;
		logic [deef_pkg::IDX_W-1:0]       pattern_index;
		logic [deef_pkg::LEN_W-1:0]       pattern_length;
		logic [deef_pkg::OCC_W-1:0]       wanted_occurrence;
	} cmd_item_t;

	typedef struct packed {
		logic                        found;
		logic [deef_pkg::OUT_W-1:0]  field_number;
		logic [deef_pkg::OUT_W-1:0]  value_number;
		logic [deef_pkg::OUT_W-1:0]  subvalue_number;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	deef_cmd_if cmd_ch();
	deef_res_if res_ch();

	delimited_element_equality_find_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.res       (res_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [deef_pkg::BYTE_W-1:0]          pat_mem [deef_pkg::PATTERN_MAX_DEF];
	logic [deef_pkg::LEN_W-1:0]           pat_len      = '0;
	logic [deef_pkg::LEN_W-1:0]           match_ptr    = '0;
	bit                                   mismatched   = 1'b0;
	logic [deef_pkg::OCC_W-1:0]           hits_to_go   = '0;
	logic [deef_pkg::COUNT_WIDTH_DEF-1:0] field_cnt    = 1;
	logic [deef_pkg::COUNT_WIDTH_DEF-1:0] value_cnt    = 1;
	logic [deef_pkg::COUNT_WIDTH_DEF-1:0] subvalue_cnt = 1;
	bit                                   hit_frozen   = 1'b0;
	bit                                   source_begun = 1'b0;
	bit                                   case_fold    = 1'b0;

	logic [deef_pkg::BYTE_W-1:0] gen_pat [deef_pkg::PATTERN_MAX_DEF];
	cmd_item_t         cmd_backlog [$];
	answer_t           answer_q [$];
	int unsigned       queued   = 0;
	int unsigned       errors   = 0;
	int unsigned       cmd_taken = 0;

	string field_tag [4] = '{"found", "field_number", "value_number", "subvalue_number"};

	function automatic logic [deef_pkg::BYTE_W-1:0] upper_if_folding(
		logic [deef_pkg::BYTE_W-1:0] c);
		if (case_fold && c >= deef_pkg::LOWER_A && c <= deef_pkg::LOWER_Z) begin
			return c - deef_pkg::CASE_OFFSET;
		end
		return c;
	endfunction

	function automatic logic [deef_pkg::COUNT_WIDTH_DEF-1:0] bump(
		logic [deef_pkg::COUNT_WIDTH_DEF-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	function automatic bit element_whole();
		return !mismatched && match_ptr == pat_len;
	endfunction

	function automatic void track_search(cmd_item_t it);
		answer_t a;
		logic [deef_pkg::BYTE_W-1:0] b;
		b = it.data_byte;
		case (it.func)
			deef_pkg::FUNC_START: begin
				pat_len      = (it.pattern_length > deef_pkg::PATTERN_MAX_DEF)
				               ? deef_pkg::LEN_W'(deef_pkg::PATTERN_MAX_DEF) : it.pattern_length;
				match_ptr    = '0;
				mismatched   = 1'b0;
				hits_to_go   = it.wanted_occurrence;
				field_cnt    = 1;
				value_cnt    = 1;
				subvalue_cnt = 1;
				hit_frozen   = 1'b0;
				source_begun = 1'b0;
			end
			deef_pkg::FUNC_PATTERN: pat_mem[it.pattern_index] = b;
			deef_pkg::FUNC_SOURCE: begin
				source_begun = 1'b1;
				if (!hit_frozen) begin
					if (b == deef_pkg::MARK_FIELD || b == deef_pkg::MARK_VALUE ||
					    b == deef_pkg::MARK_SUBVALUE) begin
						if (element_whole() && hits_to_go == 1) begin
							hits_to_go = '0;
							hit_frozen = 1'b1;
						end else begin
							if (element_whole() && hits_to_go > 1) hits_to_go--;
							mismatched = 1'b0;
							match_ptr  = '0;
							if (b == deef_pkg::MARK_FIELD) begin
								field_cnt    = bump(field_cnt);
								value_cnt    = 1;
								subvalue_cnt = 1;
							end else if (b == deef_pkg::MARK_VALUE) begin
								value_cnt    = bump(value_cnt);
								subvalue_cnt = 1;
							end else begin
								subvalue_cnt = bump(subvalue_cnt);
							end
						end
					end else if (!mismatched) begin
						if (match_ptr < pat_len && upper_if_folding(b) ==
						    upper_if_folding(pat_mem[match_ptr[deef_pkg::IDX_W-1:0]])) begin
							match_ptr++;
						end else begin
							mismatched = 1'b1;
							match_ptr  = '0;
						end
					end
				end
			end
			deef_pkg::FUNC_END: begin
				a.found = hit_frozen || (source_begun && element_whole() && hits_to_go == 1);
				a.field_number    = a.found ? field_cnt[deef_pkg::OUT_W-1:0] : '0;
				a.value_number    = a.found ? value_cnt[deef_pkg::OUT_W-1:0] : '0;
				a.subvalue_number = a.found ? subvalue_cnt[deef_pkg::OUT_W-1:0] : '0;
				answer_q.push_back(a);
			end
			default: ;
		endcase
	endfunction

	// stimulus building
	function automatic void add_cmd(deef_pkg::func_t f, logic [deef_pkg::BYTE_W-1:0] b,
	                                logic [deef_pkg::IDX_W-1:0] ix,
	                                logic [deef_pkg::LEN_W-1:0] pl,
	                                logic [deef_pkg::OCC_W-1:0] oc);
		cmd_item_t it;
		it = '{f, b, ix, pl, oc};
		if (f == deef_pkg::FUNC_PATTERN) gen_pat[ix] = b;
		cmd_backlog.push_back(it);
		queued++;
	endfunction

	function automatic void add_start(logic [deef_pkg::LEN_W-1:0] pl,
	                                  logic [deef_pkg::OCC_W-1:0] oc);
		add_cmd(deef_pkg::FUNC_START, deef_pkg::BYTE_W'($urandom),
		        deef_pkg::IDX_W'($urandom), pl, oc);
	endfunction

	function automatic void add_pat(logic [deef_pkg::IDX_W-1:0] ix,
	                                logic [deef_pkg::BYTE_W-1:0] b);
		add_cmd(deef_pkg::FUNC_PATTERN, b, ix, deef_pkg::LEN_W'($urandom),
		        deef_pkg::OCC_W'($urandom));
	endfunction

	function automatic void add_src(logic [deef_pkg::BYTE_W-1:0] b);
		add_cmd(deef_pkg::FUNC_SOURCE, b, deef_pkg::IDX_W'($urandom),
		        deef_pkg::LEN_W'($urandom), deef_pkg::OCC_W'($urandom));
	endfunction

	function automatic void add_end();
		add_cmd(deef_pkg::FUNC_END, deef_pkg::BYTE_W'($urandom), deef_pkg::IDX_W'($urandom),
		        deef_pkg::LEN_W'($urandom), deef_pkg::OCC_W'($urandom));
	endfunction

	function automatic logic [deef_pkg::BYTE_W-1:0] data_char();
		logic [deef_pkg::BYTE_W-1:0] c;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				c = deef_pkg::LOWER_A - deef_pkg::CASE_OFFSET +
				    deef_pkg::BYTE_W'($urandom_range(0, 3));
				if ($urandom_range(0, 1) != 0) c = c | deef_pkg::CASE_OFFSET;
			end
			6: c = 8'hFF;
			7: c = 8'h00;
			8: begin
				case ($urandom_range(0, 3))
					0: c = deef_pkg::LOWER_A - deef_pkg::CASE_OFFSET - 8'd1;
					1: c = deef_pkg::LOWER_Z - deef_pkg::CASE_OFFSET + 8'd1;
					2: c = deef_pkg::LOWER_A - 8'd1;
					default: c = deef_pkg::LOWER_Z + 8'd1;
				endcase
			end
			default: begin
				c = deef_pkg::BYTE_W'($urandom);
				if (c == deef_pkg::MARK_FIELD || c == deef_pkg::MARK_VALUE ||
				    c == deef_pkg::MARK_SUBVALUE) c = c ^ 8'h10;
			end
		endcase
		return c;
	endfunction

	function automatic logic [deef_pkg::BYTE_W-1:0] pick_mark();
		case ($urandom_range(0, 2))
			0: return deef_pkg::MARK_FIELD;
			1: return deef_pkg::MARK_VALUE;
			default: return deef_pkg::MARK_SUBVALUE;
		endcase
	endfunction

	function automatic void add_element(int unsigned eff);
		int unsigned len;
		logic [deef_pkg::BYTE_W-1:0] c, up;
		case ($urandom_range(0, 5))
			0, 1: begin
				for (int k = 0; k < eff; k++) begin
					c  = gen_pat[deef_pkg::IDX_W'(k)];
					up = c | deef_pkg::CASE_OFFSET;
					if (up >= deef_pkg::LOWER_A && up <= deef_pkg::LOWER_Z &&
					    $urandom_range(0, 1) != 0)
						c = c ^ deef_pkg::CASE_OFFSET;
					add_src(c);
				end
			end
			2: ;
			3: begin
				len = (eff == 0) ? 0 : $urandom_range(0, eff - 1);
				for (int k = 0; k < len; k++) add_src(gen_pat[deef_pkg::IDX_W'(k)]);
			end
			4: begin
				for (int k = 0; k < eff; k++) add_src(gen_pat[deef_pkg::IDX_W'(k)]);
				add_src(data_char());
			end
			default: begin
				len = $urandom_range(0, eff + 1);
				for (int k = 0; k < len; k++) add_src(data_char());
			end
		endcase
	endfunction

	function automatic void queue_search();
		int unsigned plen, eff, elems;
		logic [deef_pkg::OCC_W-1:0] occ;
		case ($urandom_range(0, 29))
			0: plen = $urandom_range(65, 127);
			1, 2: plen = $urandom_range(6, 64);
			default: plen = $urandom_range(0, 5);
		endcase
		case ($urandom_range(0, 9))
			0: occ = '0;
			1: occ = deef_pkg::OCC_W'($urandom);
			default: occ = deef_pkg::OCC_W'($urandom_range(1, 3));
		endcase
		add_start(deef_pkg::LEN_W'(plen), occ);
		eff = (plen > deef_pkg::PATTERN_MAX_DEF) ? deef_pkg::PATTERN_MAX_DEF : plen;
		if ($urandom_range(0, 3) != 0) begin
			for (int k = 0; k < eff; k++) add_pat(deef_pkg::IDX_W'(k), data_char());
		end
		elems = ($urandom_range(0, 14) == 0) ? 0 : $urandom_range(1, (eff > 16) ? 3 : 6);
		for (int e = 0; e < elems; e++) begin
			if (e != 0) begin
				if ($urandom_range(0, 11) == 0)
					add_pat(deef_pkg::IDX_W'($urandom_range(0, 63)), data_char());
				add_src(pick_mark());
			end
			add_element(eff);
		end
		add_end();
		case ($urandom_range(0, 5))
			0: add_end();
			1: begin
				add_src(pick_mark());
				add_element(eff);
				add_end();
			end
			default: ;
		endcase
	endfunction

	function automatic void queue_phase(int unsigned n);
		int unsigned target;
		target = queued + n;
		while (queued < target) begin
			if ($urandom_range(0, 9) == 0)
				add_cmd(deef_pkg::func_t'($urandom_range(0, 3)), deef_pkg::BYTE_W'($urandom),
				        deef_pkg::IDX_W'($urandom), deef_pkg::LEN_W'($urandom),
				        deef_pkg::OCC_W'($urandom));
			else
				queue_search();
		end
	endfunction

	task automatic settle();
		while (cmd_taken != queued || answer_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_case_fold(bit v);
		settle();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		case_fold = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		static bit fold_plan [4] = '{1'b1, 1'b0, 1'b1, 1'b0};
		arst_n                   = 1'b0;
		cfg_we                   = 1'b0;
		cfg_wdata                = 1'b0;
		cmd_ch.valid             = 1'b0;
		cmd_ch.func              = deef_pkg::FUNC_START;
		cmd_ch.data_byte         = '0;
		cmd_ch.pattern_index     = '0;
		cmd_ch.pattern_length    = '0;
		cmd_ch.wanted_occurrence = '0;
		res_ch.ready             = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		set_case_fold(1'b0);
		@(negedge clk);
		// fill the whole store so no compare ever sees an unwritten entry
		for (int k = 0; k < deef_pkg::PATTERN_MAX_DEF; k++)
			add_pat(deef_pkg::IDX_W'(k), data_char());
		// empty pattern against empty elements
		add_start(0, 2);
		add_src(deef_pkg::MARK_FIELD);
		add_src(deef_pkg::MARK_SUBVALUE);
		add_end();
		// oversized length, top index, largest occurrence, no source at all
		add_pat(63, 8'hFF);
		add_start(127, '1);
		add_end();
		// longer element, hit at end of source, repeated end, scan after end
		add_start(2, 1);
		add_pat(0, "x");
		add_pat(1, 8'hFF);
		add_src("x");
		add_src(8'hFF);
		add_src("x");
		add_src(deef_pkg::MARK_VALUE);
		add_src("x");
		add_src(8'hFF);
		add_end();
		add_end();
		add_src(deef_pkg::MARK_FIELD);
		add_end();
		// occurrence zero
		add_start(1, 0);
		add_src("x");
		add_end();
		// pattern rewritten mid-scan
		add_start(1, 1);
		add_src("q");
		add_pat(0, "q");
		add_src(deef_pkg::MARK_SUBVALUE);
		add_src("q");
		add_end();
		foreach (fold_plan[p]) begin
			set_case_fold(fold_plan[p]);
			@(negedge clk);
			queue_phase(PHASE_ITEMS);
		end
		settle();
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// sender: bursts and gaps
	cmd_item_t   cur_item;
	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;

	always @(posedge clk) begin
		bit offer;
		offer = cmd_ch.valid;
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			track_search(cur_item);
			cmd_taken <= cmd_taken + 1;
			offer = 1'b0;
		end
		if (!offer && arst_n) begin
			if (gap_left != 0) begin
				gap_left--;
			end else if (cmd_backlog.size() != 0) begin
				cur_item = cmd_backlog.pop_front();
				offer    = 1'b1;
				cmd_ch.func              <= cur_item.func;
				cmd_ch.data_byte         <= cur_item.data_byte;
				cmd_ch.pattern_index     <= cur_item.pattern_index;
				cmd_ch.pattern_length    <= cur_item.pattern_length;
				cmd_ch.wanted_occurrence <= cur_item.wanted_occurrence;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end
		end
		cmd_ch.valid <= offer;
	end

	// long receiver hold-off so the unit backs up onto its input
	int unsigned hold_left  = 0;
	int unsigned holds_done = 0;

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_done < 2 && cmd_taken >= HOLD_EVERY * (holds_done + 1)) begin
			hold_left  <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end
	end

	// receiver and checker
	logic [15:0] stall_bits = '1;
	logic [3:0]  stall_step = '0;

	always @(posedge clk) begin
		answer_t                    want;
		logic [deef_pkg::OUT_W-1:0] want_v [4];
		logic [deef_pkg::OUT_W-1:0] got_v [4];
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (answer_q.size() == 0) begin
				errors++;
				$display("%0t unexpected transaction: expected none, actual found=%0d %0h.%0h.%0h",
				         $time, res_ch.found, res_ch.field_number, res_ch.value_number,
				         res_ch.subvalue_number);
			end else begin
				want = answer_q.pop_front();
				want_v = '{deef_pkg::OUT_W'(want.found), want.field_number, want.value_number,
				           want.subvalue_number};
				got_v  = '{deef_pkg::OUT_W'(res_ch.found), res_ch.field_number,
				           res_ch.value_number, res_ch.subvalue_number};
				for (int i = 0; i < 4; i++) begin
					if (got_v[i] !== want_v[i]) begin
						errors++;
						$display("%0t %s mismatch: expected %0h, actual %0h",
						         $time, field_tag[i], want_v[i], got_v[i]);
					end
				end
			end
		end
		if (stall_step == 0) stall_bits = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
		res_ch.ready <= (hold_left == 0) && stall_bits[stall_step];
		stall_step = stall_step + 1'b1;
	end

	int unsigned cycle_count = 0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
hw/rtl/deef_pkg.sv
hw/rtl/deef_ifs.sv
hw/rtl/deef_ram.sv
hw/rtl/delimited_element_equality_find_unit.sv
dv/testbench.sv
